FILE: src/depth_sorted_slot_table_assert.svh
`ifndef DEPTH_SORTED_SLOT_TABLE_ASSERT_SVH
`define DEPTH_SORTED_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SDST_AST_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdst: same-cycle check failed");

// next-cycle implication, quiet during reset
`define SDST_AST_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdst: next-cycle check failed");

`endif

FILE: src/sdst_pkg.sv
package sdst_pkg;

  localparam int TDATA_W = 24;

  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_LIVE  = 2'd2;
  localparam logic [1:0] ST_POS_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     commit;
  } cell_ctl_t;

endpackage

FILE: src/sdst_cell.sv
module sdst_cell #(
  parameter int KW = 8,
  parameter int VW = 7,
  parameter logic [KW-1:0] RST_KEY = '0,
  parameter logic [VW-1:0] RST_VAL = '0,
  parameter logic RST_VALID = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  sdst_pkg::cell_ctl_t ctl,
  input  logic [KW-1:0]      ins_key,
  input  logic [VW-1:0]      ins_val,
  input  logic [VW-1:0]      rm_val,
  input  logic               left_le,
  input  logic [KW-1:0]      left_key,
  input  logic [VW-1:0]      left_val,
  input  logic               left_valid,
  input  logic [KW-1:0]      right_key,
  input  logic [VW-1:0]      right_val,
  input  logic               right_valid,
  input  logic               rm_in,
  output logic               le,
  output logic               rm_out,
  output logic [KW-1:0]      key,
  output logic [VW-1:0]      val,
  output logic               valid
);

  logic match;

  // entries at or below the new key stay put; the first one above it, or the first empty one, takes the new entry
  assign le     = valid && (key <= ins_key);
  assign match  = valid && (val == rm_val);
  assign rm_out = rm_in || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= RST_KEY;
      val   <= RST_VAL;
      valid <= RST_VALID;
    end else if (ctl.commit) begin
      case (ctl.op)
        sdst_pkg::CELL_INSERT: begin
          if (!le) begin
            if (left_le) begin
              key   <= ins_key;
              val   <= ins_val;
              valid <= 1'b1;
            end else begin
              key   <= left_key;
              val   <= left_val;
              valid <= left_valid;
            end
          end
        end
        sdst_pkg::CELL_REMOVE: begin
          if (rm_out) begin
            key   <= right_key;
            val   <= right_val;
            valid <= right_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/sdst_chain.sv
module sdst_chain #(
  parameter int N = 128,
  parameter int KW = 8,
  parameter int VW = 7,
  parameter logic FILL_INDEX = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sdst_pkg::cell_ctl_t  ctl,
  input  logic [KW-1:0]        ins_key,
  input  logic [VW-1:0]        ins_val,
  input  logic [VW-1:0]        rm_val,
  output logic [N-1:0]         les,
  output logic [N-1:0][VW-1:0] vals,
  output logic [N-1:0]         valids,
  output logic                 found
);

  logic [N-1:0][KW-1:0] keys;
  logic [N:0]           rms;

  assign rms[0] = 1'b0;
  assign found  = rms[N];

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic          l_le;
    logic [KW-1:0] l_key;
    logic [VW-1:0] l_val;
    logic          l_valid;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic          r_valid;

    if (k == 0) begin : g_head
      assign l_le    = 1'b1;
      assign l_key   = '0;
      assign l_val   = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_le    = les[k-1];
      assign l_key   = keys[k-1];
      assign l_val   = vals[k-1];
      assign l_valid = valids[k-1];
    end

    if (k == N - 1) begin : g_tail
      assign r_key   = '0;
      assign r_val   = '0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_key   = keys[k+1];
      assign r_val   = vals[k+1];
      assign r_valid = valids[k+1];
    end

    sdst_cell #(
      .KW       (KW),
      .VW       (VW),
      .RST_KEY  (FILL_INDEX ? KW'(k) : '0),
      .RST_VAL  (FILL_INDEX ? VW'(k) : '0),
      .RST_VALID(FILL_INDEX)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .ins_key    (ins_key),
      .ins_val    (ins_val),
      .rm_val     (rm_val),
      .left_le    (l_le),
      .left_key   (l_key),
      .left_val   (l_val),
      .left_valid (l_valid),
      .right_key  (r_key),
      .right_val  (r_val),
      .right_valid(r_valid),
      .rm_in      (rms[k]),
      .le         (les[k]),
      .rm_out     (rms[k+1]),
      .key        (keys[k]),
      .val        (vals[k]),
      .valid      (valids[k])
    );
  end

endmodule

FILE: src/depth_sorted_slot_table.sv
// Result path: an accepted command is registered, then the execute state that
// follows every accept shifts the order row and free row and registers the result onto m_tdata.
// Flow: s_tready is low while a command executes and while a result waits, so
// each command is through before the next one is taken.
// Reset: synchronous; the order row empties, the free-slot row reloads
// 0..SLOTS-1 in the same cycle, live count clears, no result pending.
module depth_sorted_slot_table #(
  parameter int SLOTS = 128,
  parameter int DEPTH_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // func[1:0], depth[9:2], object_id[16:10], position[23:17]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], slot_out[8:2], order_out[15:9], live_count[23:16]
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic                    busy;
  logic [1:0]              func;
  logic [DEPTH_WIDTH-1:0]  depth_k;
  logic [6:0]              object_id;
  logic [6:0]              position;
  logic [CW-1:0]           count;

  sdst_pkg::cell_ctl_t     ord_ctl;
  sdst_pkg::cell_ctl_t     free_ctl;
  logic [SLOTS-1:0]        ord_les;
  logic [SLOTS-1:0][IW-1:0] ord_vals;
  logic [SLOTS-1:0]        ord_valids;
  logic                    ord_found;
  logic [SLOTS-1:0][IW-1:0] free_vals;
  logic [SLOTS-1:0]        free_valids;

  logic          in_range;
  logic          live_hit;
  logic          full;
  logic [IW-1:0] id_k;
  logic [IW-1:0] head_slot;
  logic [IW-1:0] ins_pos;
  logic [IW-1:0] rd_slot;
  logic          rd_ok;
  logic [CW-1:0] count_next;
  logic [1:0]    status;
  logic [IW-1:0] slot_res;
  logic [IW-1:0] pos_res;
  logic          s_fire;

  assign s_tready = !rst && !busy && (!m_tvalid || m_tready);
  assign s_fire   = s_tvalid && s_tready;

  assign id_k      = IW'(object_id);
  assign in_range  = (32'(object_id) < SLOTS);
  assign live_hit  = in_range && ord_found;
  assign full      = (count == CW'(SLOTS));
  assign head_slot = free_vals[0];
  assign rd_ok     = (32'(position) < 32'(count));

  always_comb begin
    ord_ctl  = '{op: sdst_pkg::CELL_HOLD, commit: 1'b0};
    free_ctl = '{op: sdst_pkg::CELL_HOLD, commit: 1'b0};
    case (func)
      sdst_pkg::FUNC_CREATE: begin
        ord_ctl  = '{op: sdst_pkg::CELL_INSERT, commit: busy && !full};
        free_ctl = '{op: sdst_pkg::CELL_REMOVE, commit: busy && !full};
      end
      sdst_pkg::FUNC_DELETE: begin
        ord_ctl  = '{op: sdst_pkg::CELL_REMOVE, commit: busy && in_range};
        free_ctl = '{op: sdst_pkg::CELL_INSERT, commit: busy && live_hit};
      end
      default: begin
      end
    endcase
  end

  sdst_chain #(
    .N         (SLOTS),
    .KW        (DEPTH_WIDTH),
    .VW        (IW),
    .FILL_INDEX(1'b0)
  ) u_order (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ord_ctl),
    .ins_key(depth_k),
    .ins_val(head_slot),
    .rm_val (id_k),
    .les    (ord_les),
    .vals   (ord_vals),
    .valids (ord_valids),
    .found  (ord_found)
  );

  // free slots kept ascending, so the head is always the lowest free id
  sdst_chain #(
    .N         (SLOTS),
    .KW        (IW),
    .VW        (IW),
    .FILL_INDEX(1'b1)
  ) u_free (
    .clk    (clk),
    .rst    (rst),
    .ctl    (free_ctl),
    .ins_key(id_k),
    .ins_val(id_k),
    .rm_val (head_slot),
    .les    (),
    .vals   (free_vals),
    .valids (free_valids),
    .found  ()
  );

  // le pattern is a run of ones then zeros; the first zero is the insert point
  always_comb begin
    ins_pos = '0;
    rd_slot = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (((k == 0) || ord_les[(k == 0) ? 0 : k - 1]) && !ord_les[k]) begin
        ins_pos = ins_pos | IW'(k);
      end
      if ((32'(position) == k) && ord_valids[k]) begin
        rd_slot = rd_slot | ord_vals[k];
      end
    end
  end

  always_comb begin
    status     = sdst_pkg::ST_OK;
    slot_res   = '0;
    pos_res    = '0;
    count_next = count;
    case (func)
      sdst_pkg::FUNC_CREATE: begin
        if (full || !free_valids[0]) begin
          status = sdst_pkg::ST_FULL;
        end else begin
          slot_res   = head_slot;
          pos_res    = ins_pos;
          count_next = count + CW'(1);
        end
      end
      sdst_pkg::FUNC_DELETE: begin
        if (!live_hit) begin
          status = sdst_pkg::ST_NOT_LIVE;
        end else begin
          count_next = count - CW'(1);
        end
      end
      sdst_pkg::FUNC_READ: begin
        if (!rd_ok) begin
          status = sdst_pkg::ST_POS_EMPTY;
        end else begin
          slot_res = rd_slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s_fire) begin
        busy      <= 1'b1;
        func      <= s_tdata[1:0];
        depth_k   <= DEPTH_WIDTH'(s_tdata[9:2]);
        object_id <= s_tdata[16:10];
        position  <= s_tdata[23:17];
      end else if (busy) begin
        busy     <= 1'b0;
        count    <= count_next;
        m_tvalid <= 1'b1;
        m_tdata  <= {8'(32'(count_next)), 7'(32'(pos_res)), 7'(32'(slot_res)), status};
      end
    end
  end

endmodule

FILE: src/sdst_checker.sv
`include "depth_sorted_slot_table_assert.svh"

module sdst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic s_fire;
  logic is_full;

  assign s_fire  = s_tvalid && s_tready;
  assign is_full = m_tvalid && (m_tdata[1:0] == sdst_pkg::ST_FULL);

  // one command in flight: no second transaction right after the first
  `SDST_AST_NXT(a_one_in_flight, s_fire, !s_tready)

  // a stalled result holds
  `SDST_AST_NXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // a full table reports no slot and no order position
  `SDST_AST_NOW(a_full_zero, is_full, m_tdata[15:2] == 14'd0)

  // every new result comes from a command taken, registered and then executed in the busy state
  `SDST_AST_NOW(a_result_source, $rose(m_tvalid), $past(s_fire, 2))

endmodule

bind depth_sorted_slot_table sdst_checker u_sdst_checker (.*);

FILE: test/tb_depth_sorted_slot_table.sv
module tb_depth_sorted_slot_table;

  localparam int SLOTS = 128;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] FUNC_NOP = 2'd3;

  // same layout as m_tdata, lowest field last
  typedef struct packed {
    logic [7:0] live;
    logic [6:0] order;
    logic [6:0] slot;
    logic [1:0] status;
  } sdst_result_t;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  // func[1:0], depth[9:2], object_id[16:10], position[23:17]
  logic [sdst_pkg::TDATA_W-1:0] s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  // status[1:0], slot_out[8:2], order_out[15:9], live_count[23:16]
  logic [sdst_pkg::TDATA_W-1:0] m_tdata;

  depth_sorted_slot_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor state
  logic       obj_live [SLOTS];
  logic [7:0] obj_depth [SLOTS];
  logic [6:0] draw_order [SLOTS];
  int         n_live;

  sdst_result_t pending_results[$];
  int mismatches;
  int n_sent, n_full, n_not_live, n_pos_empty, peak_live;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = quiet || ($urandom_range(0, 99) >= 36);
    end
  end

  function automatic sdst_result_t predict_cmd(logic [1:0] f, logic [7:0] d,
                                                logic [6:0] id, logic [6:0] pos);
    sdst_result_t r;
    int slot;
    int at;
    r = '0;
    case (f)
      sdst_pkg::FUNC_CREATE: begin
        slot = 0;
        while (slot < SLOTS && obj_live[slot]) slot++;
        if (n_live >= SLOTS || slot >= SLOTS) begin
          r.status = sdst_pkg::ST_FULL;
        end else begin
          // land after every entry of equal or lower depth
          at = 0;
          while (at < n_live && obj_depth[draw_order[at]] <= d) at++;
          for (int k = n_live; k > at; k--) draw_order[k] = draw_order[k-1];
          draw_order[at] = slot[6:0];
          obj_live[slot] = 1'b1;
          obj_depth[slot] = d;
          n_live++;
          r.slot = slot[6:0];
          r.order = at[6:0];
        end
      end
      sdst_pkg::FUNC_DELETE: begin
        if (!obj_live[id]) begin
          r.status = sdst_pkg::ST_NOT_LIVE;
        end else begin
          at = 0;
          while (at < n_live && draw_order[at] != id) at++;
          if (at < n_live) begin
            for (int k = at; k + 1 < n_live; k++) draw_order[k] = draw_order[k+1];
            n_live--;
          end
          obj_live[id] = 1'b0;
        end
      end
      sdst_pkg::FUNC_READ: begin
        if (pos >= n_live) r.status = sdst_pkg::ST_POS_EMPTY;
        else r.slot = draw_order[pos];
      end
      default: ;
    endcase
    r.live = n_live[7:0];
    return r;
  endfunction

  task automatic send_cmd(input logic [1:0] f, input logic [7:0] d,
                          input logic [6:0] id, input logic [6:0] pos);
    sdst_result_t r;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 36) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {pos, id, d, f};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    r = predict_cmd(f, d, id, pos);
    pending_results.push_back(r);
    n_sent++;
    if (f == sdst_pkg::FUNC_CREATE && r.status == sdst_pkg::ST_FULL) n_full++;
    if (r.status == sdst_pkg::ST_NOT_LIVE) n_not_live++;
    if (r.status == sdst_pkg::ST_POS_EMPTY) n_pos_empty++;
    if (n_live > peak_live) peak_live = n_live;
  endtask

  function automatic logic [7:0] rand_depth();
    // half the time from four values so equal depths pile up
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 3) * 85);
  endfunction

  function automatic logic [6:0] rand_field();
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [6:0] pick_live_id();
    if (n_live == 0) return rand_field();
    return draw_order[$urandom_range(0, n_live - 1)];
  endfunction

  // result checker
  always @(posedge clk) begin
    sdst_result_t got;
    sdst_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d order %0d live %0d",
                   got.status, got.slot, got.order, got.live);
      end else begin
        exp = pending_results.pop_front();
        if (got.status !== exp.status || got.slot !== exp.slot ||
            got.order !== exp.order || got.live !== exp.live) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status %0d slot %0d order %0d live %0d,",
                     exp.status, exp.slot, exp.order, exp.live,
                     " got status %0d slot %0d order %0d live %0d",
                     got.status, got.slot, got.order, got.live);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic test_directed();
    // empty table corner cases
    send_cmd(sdst_pkg::FUNC_READ, 8'h00, 7'h00, 7'd0);
    send_cmd(sdst_pkg::FUNC_READ, 8'hff, 7'h7f, 7'd127);
    send_cmd(sdst_pkg::FUNC_DELETE, 8'h00, 7'd0, 7'h00);
    send_cmd(sdst_pkg::FUNC_DELETE, 8'hff, 7'd127, 7'h7f);
    send_cmd(FUNC_NOP, 8'h00, 7'h00, 7'h00);
    // creates with extreme and equal depths; slots 0..4
    send_cmd(sdst_pkg::FUNC_CREATE, 8'd255, 7'h7f, 7'h7f);
    send_cmd(sdst_pkg::FUNC_CREATE, 8'd0, 7'h00, 7'h00);
    send_cmd(sdst_pkg::FUNC_CREATE, 8'd128, 7'h55, 7'h2a);
    send_cmd(sdst_pkg::FUNC_CREATE, 8'd128, 7'h2a, 7'h55);
    send_cmd(sdst_pkg::FUNC_CREATE, 8'd0, 7'h7f, 7'h00);
    for (int p = 0; p <= 5; p++) send_cmd(sdst_pkg::FUNC_READ, 8'h5a, 7'h00, 7'(p));
    send_cmd(sdst_pkg::FUNC_READ, 8'h00, 7'h7f, 7'd127);
    // free a middle slot, then the lowest free one is reused
    send_cmd(sdst_pkg::FUNC_DELETE, 8'h00, 7'd1, 7'h7f);
    send_cmd(sdst_pkg::FUNC_CREATE, 8'd128, 7'h00, 7'h00);
    send_cmd(sdst_pkg::FUNC_DELETE, 8'hff, 7'd1, 7'h00);
    send_cmd(sdst_pkg::FUNC_DELETE, 8'hff, 7'd1, 7'h00);
    send_cmd(sdst_pkg::FUNC_READ, 8'h00, 7'h00, 7'd0);
    send_cmd(FUNC_NOP, 8'hff, 7'h7f, 7'h7f);
  endtask

  task automatic test_fill_table();
    logic [6:0] victim;
    while (n_live < SLOTS) begin
      if ($urandom_range(0, 9) == 0)
        send_cmd(sdst_pkg::FUNC_READ, rand_depth(), rand_field(),
                 7'($urandom_range(0, n_live)));
      else
        send_cmd(sdst_pkg::FUNC_CREATE, rand_depth(), rand_field(), rand_field());
    end
    repeat (3) send_cmd(sdst_pkg::FUNC_CREATE, rand_depth(), rand_field(), rand_field());
    send_cmd(sdst_pkg::FUNC_READ, rand_depth(), rand_field(), 7'd127);
    send_cmd(sdst_pkg::FUNC_READ, rand_depth(), rand_field(), 7'd0);
    victim = pick_live_id();
    send_cmd(sdst_pkg::FUNC_DELETE, rand_depth(), victim, rand_field());
    send_cmd(sdst_pkg::FUNC_CREATE, rand_depth(), rand_field(), rand_field());
    send_cmd(sdst_pkg::FUNC_CREATE, rand_depth(), rand_field(), rand_field());
    // tear down in random order
    while (n_live > 0) begin
      if ($urandom_range(0, 7) == 0)
        send_cmd(sdst_pkg::FUNC_READ, rand_depth(), rand_field(), rand_field());
      else
        send_cmd(sdst_pkg::FUNC_DELETE, rand_depth(), pick_live_id(), rand_field());
    end
  endtask

  task automatic test_random_mix();
    int roll;
    for (int i = 0; i < 500; i++) begin
      quiet = (i < 150);
      roll = $urandom_range(0, 99);
      if (roll < 38)
        send_cmd(sdst_pkg::FUNC_CREATE, rand_depth(), rand_field(), rand_field());
      else if (roll < 72)
        send_cmd(sdst_pkg::FUNC_DELETE, rand_depth(),
                 ($urandom_range(0, 4) != 0) ? pick_live_id() : rand_field(), rand_field());
      else if (roll < 95)
        send_cmd(sdst_pkg::FUNC_READ, rand_depth(), rand_field(),
                 ($urandom_range(0, 4) != 0 && n_live > 0) ?
                   7'($urandom_range(0, n_live - 1)) : rand_field());
      else
        send_cmd(FUNC_NOP, rand_depth(), rand_field(), rand_field());
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    quiet = 1'b0;
    mismatches = 0;
    n_sent = 0;
    n_full = 0;
    n_not_live = 0;
    n_pos_empty = 0;
    peak_live = 0;
    n_live = 0;
    for (int k = 0; k < SLOTS; k++) begin
      obj_live[k] = 1'b0;
      obj_depth[k] = '0;
      draw_order[k] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fill_table();
    test_random_mix();

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    mismatches += pending_results.size();

    $display("ran %0d commands, peak of %0d live objects", n_sent, peak_live);
    $display("rejects seen: %0d full-table creates, %0d dead deletes, %0d empty reads",
             n_full, n_not_live, n_pos_empty);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: depth_sorted_slot_table.f
+incdir+src
src/sdst_pkg.sv
src/sdst_cell.sv
src/sdst_chain.sv
src/depth_sorted_slot_table.sv
src/sdst_checker.sv
test/tb_depth_sorted_slot_table.sv
